### src/indexed_shift_list_macros.svh
// ---------------------------------------------------------------------------
// indexed_shift_list assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_MACROS_SVH
`define INDEXED_SHIFT_LIST_MACROS_SVH

// same-cycle implication
`define ISL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/isl_pkg.sv
// ---------------------------------------------------------------------------
// isl_pkg
// Shared field widths, request and status codes, and the cell control type.
// ---------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [REQ_W-1:0]         t_req;
    typedef logic [STATUS_W-1:0]      t_status;

    // request codes
    localparam t_req REQ_PUSH_BACK = 3'd0;
    localparam t_req REQ_INSERT_AT = 3'd1;
    localparam t_req REQ_REMOVE_AT = 3'd2;
    localparam t_req REQ_POP_BACK  = 3'd3;
    localparam t_req REQ_READ_BACK = 3'd4;
    localparam t_req REQ_ACCESS_AT = 3'd5;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_INDEX = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_EMPTY = 2'd3;

    // per-cell update command
    typedef struct packed {
        logic load;        // take the request word
        logic take_left;   // take lower neighbour (insert shift)
        logic take_right;  // take upper neighbour (remove shift)
    } t_cell_ctl;

endpackage

`default_nettype wire

### src/isl_ifs.sv
// ---------------------------------------------------------------------------
// isl request / response interfaces
// Valid-ready channels carrying the list request and its response.
// ---------------------------------------------------------------------------
`default_nettype none

interface isl_req_if;
    import isl_pkg::*;
    logic  valid;
    logic  ready;
    t_req  req_type;
    logic  [POS_W-1:0] position;
    t_word word_in;
    logic  write_enable;

    modport source (output valid, req_type, position, word_in, write_enable, input ready);
    modport sink   (input valid, req_type, position, word_in, write_enable, output ready);
endinterface

interface isl_rsp_if;
    import isl_pkg::*;
    logic    valid;
    logic    ready;
    t_word   word_out;
    logic    [LEN_W-1:0] list_length;
    t_status status;

    modport source (output valid, word_out, list_length, status, input ready);
    modport sink   (input valid, word_out, list_length, status, output ready);
endinterface

`default_nettype wire

### src/isl_cell.sv
// ---------------------------------------------------------------------------
// isl_cell
// One list slot: holds, loads the request word, or takes a neighbour's value.
// ---------------------------------------------------------------------------
`default_nettype none

module isl_cell
    import isl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_word     i_left,
    input  wire t_word     i_right,
    input  wire t_word     i_word,
    output t_word          o_data
);

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_word;
        end else if (i_ctl.take_left) begin
            n_data = i_left;
        end else if (i_ctl.take_right) begin
            n_data = i_right;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### src/indexed_shift_list.sv
// ---------------------------------------------------------------------------
// indexed_shift_list
// Fixed-capacity ordered list of signed 32-bit words built as a row of cells.
// ---------------------------------------------------------------------------
// A request (push back, insert at, remove at, pop back, read back, indexed
// read/write) is answered in the next cycle from an output register; one
// request per cycle is sustained while the response side keeps up. The list
// sits in a row of DEPTH cells: on insert each cell above the index, up to
// the length, takes its lower neighbour's word and the cell at the index loads
// the new one; on remove each occupied cell from the index upward but the last
// takes its upper neighbour's word. All cells move at once, whatever the shift
// distance. Reads pick one cell through an AND-OR select across the row. Each
// response carries the word read (zero unless a read succeeded), the length
// after the request and a status: ok, index out of range, full or empty. A
// refused request leaves the list untouched. Codes six and seven are answered
// ok with no change. Entry contents have no reset; only the length and the
// output valid flag are cleared. list_length is the length modulo 32.
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_shift_list_macros.svh"

module indexed_shift_list
    import isl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    isl_req_if.sink    i_req,
    isl_rsp_if.source  o_rsp
);

    // count must hold DEPTH itself; compares run at the wider of count/position
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [CMP_W-1:0] t_cmp;

    // ---------------------------------------------------------------- state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             r_out_valid;
    t_word            r_word;
    logic [LEN_W-1:0] r_len;
    t_status          r_status;

    // ---------------------------------------------------------------- decode
    logic    accept;
    t_cmp    pos_x;
    t_cmp    cnt_x;
    logic    full;
    logic    empty;
    t_status st;
    logic    do_push;
    logic    do_ins;
    logic    do_rem;
    logic    do_pop;
    logic    do_wr;
    logic    rd_back;
    logic    rd_at;
    t_cmp    rd_idx;
    t_word   rd_word;

    // output register frees up as soon as its contents are taken
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign pos_x = CMP_W'(i_req.position);
    assign cnt_x = CMP_W'(r_count);
    assign full  = (cnt_x >= CMP_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        st      = ST_OK;
        do_push = 1'b0;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_pop  = 1'b0;
        do_wr   = 1'b0;
        rd_back = 1'b0;
        rd_at   = 1'b0;
        if (accept) begin
            case (i_req.req_type)
                REQ_PUSH_BACK: begin
                    if (full) st = ST_FULL;
                    else      do_push = 1'b1;
                end
                REQ_INSERT_AT: begin
                    // index check wins over the full check
                    if (pos_x > cnt_x) st = ST_INDEX;
                    else if (full)     st = ST_FULL;
                    else               do_ins = 1'b1;
                end
                REQ_REMOVE_AT: begin
                    if (pos_x >= cnt_x) st = ST_INDEX;
                    else                do_rem = 1'b1;
                end
                REQ_POP_BACK: begin
                    if (empty) st = ST_EMPTY;
                    else       do_pop = 1'b1;
                end
                REQ_READ_BACK: begin
                    if (empty) st = ST_EMPTY;
                    else       rd_back = 1'b1;
                end
                REQ_ACCESS_AT: begin
                    if (pos_x >= cnt_x)          st = ST_INDEX;
                    else if (i_req.write_enable) do_wr = 1'b1;
                    else                         rd_at = 1'b1;
                end
                default: begin
                    // unused codes: no change, status ok
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_push || do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem || do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------- cell row
    t_word     cell_q   [DEPTH];
    t_cell_ctl cell_ctl [DEPTH];
    logic [DEPTH-1:0] load_vec;

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        localparam t_cmp JX = CMP_W'(j);
        t_word left_d;
        t_word right_d;

        // push loads the slot just past the end; insert/write load at the index
        assign cell_ctl[j].load       = (do_push && JX == cnt_x) ||
                                        ((do_ins || do_wr) && JX == pos_x);
        assign cell_ctl[j].take_left  = do_ins && JX > pos_x && JX <= cnt_x;
        assign cell_ctl[j].take_right = do_rem && JX >= pos_x && (JX + t_cmp'(1)) < cnt_x;
        assign load_vec[j]            = cell_ctl[j].load;

        // end cells never shift off the row; tie the missing neighbour to self
        if (j == 0) begin : g_lo
            assign left_d = cell_q[j];
        end else begin : g_lo_n
            assign left_d = cell_q[j-1];
        end
        if (j == DEPTH - 1) begin : g_hi
            assign right_d = cell_q[j];
        end else begin : g_hi_n
            assign right_d = cell_q[j+1];
        end

        isl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[j]),
            .i_left  (left_d),
            .i_right (right_d),
            .i_word  (i_req.word_in),
            .o_data  (cell_q[j])
        );
    end

    // ---------------------------------------------------------------- read select
    assign rd_idx = rd_back ? (cnt_x - t_cmp'(1)) : pos_x;

    always_comb begin
        rd_word = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if ((rd_back || rd_at) && CMP_W'(j) == rd_idx) begin
                rd_word = rd_word | cell_q[j];
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word   <= rd_word;
            r_len    <= LEN_W'(n_count);
            r_status <= st;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.word_out    = r_word;
    assign o_rsp.list_length = r_len;
    assign o_rsp.status      = r_status;

    // ---------------------------------------------------------------- checks
    `ISL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, CMP_W'(r_count) <= CMP_W'(DEPTH), "list length beyond capacity")
    `ISL_ASSERT_NOW(a_one_load, i_clk, i_rst_n, 1'b1, $onehot0(load_vec), "more than one cell loads the request word")
    `ISL_ASSERT_NEXT(a_refused_hold, i_clk, i_rst_n, accept && st != ST_OK, $stable(r_count), "refused request changed the length")
    `ISL_ASSERT_NOW(a_zero_on_fail, i_clk, i_rst_n, r_out_valid && r_status != ST_OK, r_word == '0, "refused request returned a word")
    `ISL_ASSERT_NOW(a_empty_len, i_clk, i_rst_n, r_out_valid && r_status == ST_EMPTY, r_len == '0, "empty status with non-zero length")

endmodule

`default_nettype wire

### tb/sv/tb_indexed_shift_list.sv
// ---------------------------------------------------------------------------
// tb_indexed_shift_list
// Self-checking bench for the indexed shift list: a queue-fed request driver,
// a response monitor and an in-bench list model that predicts every response.
// ---------------------------------------------------------------------------
module tb_indexed_shift_list;
    timeunit 1ns;
    timeprecision 1ps;

    import isl_pkg::*;

    localparam int LIST_DEPTH      = 16;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int CALM_TAIL       = 150;  // last requests run with no idling
    localparam int SETTLE_CYCLES   = 16;   // drain time after the last response

    // codes outside the defined set, answered ok with no change
    localparam t_req REQ_SPARE_6 = 3'd6;
    localparam t_req REQ_SPARE_7 = 3'd7;

    localparam t_word WORD_MIN = 32'h8000_0000;
    localparam t_word WORD_MAX = 32'h7FFF_FFFF;

    typedef struct {
        t_req             kind;
        logic [POS_W-1:0] pos;
        t_word            word;
        logic             wr;
    } t_list_request;

    typedef struct {
        t_word            word;
        logic [LEN_W-1:0] len;
        t_status          status;
    } t_list_response;

    // -----------------------------------------------------------------------
    // clock, reset, channels, block under test
    // -----------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    isl_req_if req_if ();
    isl_rsp_if rsp_if ();

    indexed_shift_list #(
        .DEPTH (LIST_DEPTH)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // -----------------------------------------------------------------------
    // list model: contents and length as the block should hold them
    // -----------------------------------------------------------------------
    t_word model_cells [LIST_DEPTH];
    int    model_fill = 0;

    // tallies for the closing summary
    int kind_seen   [8];
    int status_seen [4];
    int peak_fill = 0;

    // Applies one accepted request to the model and returns the response
    // the block owes for it. Refusals leave cells and length untouched.
    function automatic t_list_response apply_request(t_list_request r);
        t_list_response rsp;
        int             j;
        rsp.word   = '0;
        rsp.status = ST_OK;
        case (r.kind)
            REQ_PUSH_BACK: begin
                if (model_fill >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    model_cells[model_fill] = r.word;
                    model_fill++;
                end
            end
            REQ_INSERT_AT: begin
                // index check takes priority over the full check
                if (int'(r.pos) > model_fill) begin
                    rsp.status = ST_INDEX;
                end else if (model_fill >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (j = model_fill; j > int'(r.pos); j--)
                        model_cells[j] = model_cells[j-1];
                    model_cells[r.pos] = r.word;
                    model_fill++;
                end
            end
            REQ_REMOVE_AT: begin
                if (int'(r.pos) >= model_fill) begin
                    rsp.status = ST_INDEX;
                end else begin
                    for (j = int'(r.pos); j + 1 < model_fill; j++)
                        model_cells[j] = model_cells[j+1];
                    model_fill--;
                end
            end
            REQ_POP_BACK: begin
                if (model_fill == 0) rsp.status = ST_EMPTY;
                else model_fill--;
            end
            REQ_READ_BACK: begin
                if (model_fill == 0) rsp.status = ST_EMPTY;
                else rsp.word = model_cells[model_fill-1];
            end
            REQ_ACCESS_AT: begin
                if (int'(r.pos) >= model_fill) rsp.status = ST_INDEX;
                else if (r.wr) model_cells[r.pos] = r.word;
                else rsp.word = model_cells[r.pos];
            end
            default: ;  // spare codes: nothing happens
        endcase
        rsp.len = model_fill[LEN_W-1:0];
        kind_seen[r.kind]++;
        status_seen[rsp.status]++;
        if (model_fill > peak_fill) peak_fill = model_fill;
        return rsp;
    endfunction

    // -----------------------------------------------------------------------
    // stimulus planning; plan_fill tracks the length the plan will leave
    // -----------------------------------------------------------------------
    t_list_request  pending_reqs [$];
    t_list_response owed_rsps    [$];
    int plan_fill    = 0;
    bit plan_growing = 1'b1;

    function automatic void queue_request(t_req kind, int pos, t_word word, logic wr);
        t_list_request r;
        r.kind = kind;
        r.pos  = pos[POS_W-1:0];
        r.word = word;
        r.wr   = wr;
        pending_reqs.push_back(r);
        case (kind)
            REQ_PUSH_BACK: if (plan_fill < LIST_DEPTH) plan_fill++;
            REQ_INSERT_AT: if (pos <= plan_fill && plan_fill < LIST_DEPTH) plan_fill++;
            REQ_REMOVE_AT: if (pos < plan_fill) plan_fill--;
            REQ_POP_BACK:  if (plan_fill > 0) plan_fill--;
            default: ;
        endcase
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 11))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Mostly well-formed traffic that sweeps the list from empty to full and
    // back, with a little noise. Returns 0 for a spare code, which the block
    // ignores.
    function automatic bit queue_random_request();
        int    roll;
        int    pos;
        t_req  kind;
        t_word word;
        logic  wr;
        roll = $urandom_range(0, 99);
        word = pick_word();
        wr   = 1'($urandom_range(0, 1));
        pos  = $urandom_range(0, LIST_DEPTH);
        if (roll < 2) begin
            kind = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
        end else if (roll < 10) begin
            kind = t_req'($urandom_range(0, 5));
        end else begin
            // turn round at the ends, but not always at once, so full and
            // empty refusals still turn up
            if (plan_fill == LIST_DEPTH && $urandom_range(0, 3) != 0) plan_growing = 1'b0;
            if (plan_fill == 0 && $urandom_range(0, 3) != 0) plan_growing = 1'b1;
            roll = $urandom_range(0, 99);
            if (plan_growing)
                kind = roll < 40 ? REQ_PUSH_BACK : roll < 70 ? REQ_INSERT_AT :
                       roll < 85 ? REQ_ACCESS_AT : roll < 90 ? REQ_READ_BACK :
                       roll < 95 ? REQ_REMOVE_AT : REQ_POP_BACK;
            else
                kind = roll < 35 ? REQ_REMOVE_AT : roll < 65 ? REQ_POP_BACK :
                       roll < 85 ? REQ_ACCESS_AT : roll < 92 ? REQ_READ_BACK :
                       roll < 96 ? REQ_PUSH_BACK : REQ_INSERT_AT;
            case (kind)
                REQ_INSERT_AT: pos = $urandom_range(0, plan_fill);
                REQ_REMOVE_AT, REQ_ACCESS_AT:
                    pos = (plan_fill == 0) ? 0 : $urandom_range(0, plan_fill - 1);
                default: ;
            endcase
            // boundary index: end insert is legal, remove/access is refused
            if ($urandom_range(0, 15) == 0) pos = plan_fill;
        end
        queue_request(kind, pos, word, wr);
        return kind != REQ_SPARE_6 && kind != REQ_SPARE_7;
    endfunction

    // idle/stall rate, re-chosen now and then so quiet stretches appear
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 25;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // request driver
    // -----------------------------------------------------------------------
    t_list_request in_flight;
    int reqs_accepted = 0;
    int total_reqs    = 0;
    int idle_left     = 0;
    int drv_idle_pct  = 4;
    int rsp_stall_pct = 4;
    int cycle_no      = 0;

    always @(posedge clk) begin
        cycle_no++;
        if (cycle_no % 256 == 0) begin
            drv_idle_pct  = pick_idle_pct();
            rsp_stall_pct = pick_idle_pct();
        end
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            idle_left = 0;
        end else begin
            // a request taken at this edge: predict its response now
            if (req_if.valid && req_if.ready) begin
                owed_rsps.push_back(apply_request(in_flight));
                reqs_accepted++;
            end
            // payload only moves once the current request is gone
            if (!req_if.valid || req_if.ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() >= CALM_TAIL &&
                             $urandom_range(0, 99) < drv_idle_pct) begin
                    idle_left = $urandom_range(1, 16) - 1;
                    req_if.valid <= 1'b0;
                end else begin
                    in_flight = pending_reqs.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.req_type     <= in_flight.kind;
                    req_if.position     <= in_flight.pos;
                    req_if.word_in      <= in_flight.word;
                    req_if.write_enable <= in_flight.wr;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // response monitor and back-pressure
    // -----------------------------------------------------------------------
    t_list_response want_rsp;
    int mismatches  = 0;
    int rsp_checked = 0;
    int stall_left  = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_rsps.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected response: word %0d length %0d status %0d",
                             $time, rsp_if.word_out, rsp_if.list_length, rsp_if.status);
                end else begin
                    want_rsp = owed_rsps.pop_front();
                    rsp_checked++;
                    if (rsp_if.word_out !== want_rsp.word) begin
                        mismatches++;
                        $display("%0t: word_out mismatch: expected %0d, actual %0d",
                                 $time, want_rsp.word, rsp_if.word_out);
                    end
                    if (rsp_if.list_length !== want_rsp.len) begin
                        mismatches++;
                        $display("%0t: list_length mismatch: expected %0d, actual %0d",
                                 $time, want_rsp.len, rsp_if.list_length);
                    end
                    if (rsp_if.status !== want_rsp.status) begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want_rsp.status, rsp_if.status);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (pending_reqs.size() >= CALM_TAIL &&
                         $urandom_range(0, 99) < rsp_stall_pct) begin
                stall_left = $urandom_range(1, 16) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // run control
    // -----------------------------------------------------------------------
    int n_random;

    initial begin
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_PUSH_BACK;
        req_if.position     = '0;
        req_if.word_in      = '0;
        req_if.write_enable = 1'b0;
        rsp_if.ready        = 1'b0;
        foreach (model_cells[k]) model_cells[k] = '0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        foreach (status_seen[k]) status_seen[k] = 0;

        // directed: refusals on an empty list
        queue_request(REQ_POP_BACK,  0, '0, 1'b0);
        queue_request(REQ_READ_BACK, 0, '0, 1'b0);
        queue_request(REQ_REMOVE_AT, 0, '0, 1'b0);
        queue_request(REQ_ACCESS_AT, 0, '0, 1'b0);
        queue_request(REQ_INSERT_AT, 1, WORD_MAX, 1'b0);
        // word extremes, end and middle insert, indexed write then read
        queue_request(REQ_INSERT_AT, 0, WORD_MIN, 1'b0);
        queue_request(REQ_PUSH_BACK, 0, WORD_MAX, 1'b0);
        queue_request(REQ_PUSH_BACK, 0, '1, 1'b0);
        queue_request(REQ_READ_BACK, 0, '0, 1'b0);
        queue_request(REQ_INSERT_AT, 3, 32'h1234_5678, 1'b0);
        queue_request(REQ_INSERT_AT, 1, 32'hA5A5_A5A5, 1'b0);
        queue_request(REQ_ACCESS_AT, 2, 32'h5A5A_5A5A, 1'b1);
        queue_request(REQ_ACCESS_AT, 2, '0, 1'b0);
        queue_request(REQ_ACCESS_AT, 5, '0, 1'b0);   // index equal to length
        queue_request(REQ_REMOVE_AT, 5, '0, 1'b0);   // index equal to length
        queue_request(REQ_REMOVE_AT, 0, '0, 1'b0);
        queue_request(REQ_REMOVE_AT, 3, '0, 1'b0);   // last entry
        queue_request(REQ_SPARE_6, 0, WORD_MAX, 1'b1);
        queue_request(REQ_SPARE_7, 16, WORD_MIN, 1'b1);
        // fill up, then refusals on a full list
        while (plan_fill < LIST_DEPTH) queue_request(REQ_PUSH_BACK, 0, pick_word(), 1'b0);
        queue_request(REQ_PUSH_BACK, 0, WORD_MIN, 1'b0);
        queue_request(REQ_INSERT_AT, 16, WORD_MIN, 1'b0);
        queue_request(REQ_ACCESS_AT, 16, WORD_MIN, 1'b1);
        queue_request(REQ_POP_BACK,  0, '0, 1'b0);
        queue_request(REQ_INSERT_AT, 16, '0, 1'b0);  // beyond length: bad index
        queue_request(REQ_INSERT_AT, 15, WORD_MAX, 1'b0);
        queue_request(REQ_ACCESS_AT, 15, '0, 1'b0);
        plan_growing = 1'b0;

        n_random = 0;
        while (n_random < RANDOM_REQUESTS) begin
            if (queue_random_request()) n_random++;
        end
        total_reqs = pending_reqs.size();

        // single synchronous reset at the start of the run
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (reqs_accepted < total_reqs) @(posedge clk);
        while (owed_rsps.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests: push %0d, insert %0d, remove %0d, pop %0d, %s",
                 reqs_accepted, kind_seen[REQ_PUSH_BACK], kind_seen[REQ_INSERT_AT],
                 kind_seen[REQ_REMOVE_AT], kind_seen[REQ_POP_BACK],
                 $sformatf("read back %0d, indexed %0d, spare %0d",
                           kind_seen[REQ_READ_BACK], kind_seen[REQ_ACCESS_AT],
                           kind_seen[REQ_SPARE_6] + kind_seen[REQ_SPARE_7]));
        $display("Refused %0d bad index, %0d full, %0d empty; peak length %0d; %0d checked",
                 status_seen[ST_INDEX], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 peak_fill, rsp_checked);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
